>>> rtl/core/bdc_pkg.sv
// Package: shared types and constants of the button debounce and click detector.
`default_nettype none
package bdc_pkg;

	// Width of every mask field and of the raw level field.
	localparam int unsigned FIELD_LANES = 16;
	localparam int unsigned AGE_W       = 16;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned CFG_IDX_W   = 4;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef logic [AGE_W-1:0]       age_t;
	typedef logic [FIELD_LANES-1:0] mask_t;
	typedef logic [COUNT_W-1:0]     count_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam age_t AGE_MAX = '1;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_DEBOUNCE     = 4'd0;
	localparam cfg_idx_t REG_LONG_PRESS   = 4'd1;
	localparam cfg_idx_t REG_DOUBLE_CLICK = 4'd2;
	localparam cfg_idx_t REG_BUTTON_COUNT = 4'd3;

	// Reset values of the configuration registers.
	localparam age_t   DEBOUNCE_RST     = 16'd50;
	localparam age_t   LONG_PRESS_RST   = 16'd1000;
	localparam age_t   DOUBLE_CLICK_RST = 16'd400;
	localparam count_t BUTTON_COUNT_RST = 5'd16;

	typedef struct packed {
		age_t debounce_ms;
		age_t long_press_ms;
		age_t double_click_ms;
	} timing_cfg_t;

	typedef struct packed {
		logic last_raw;
		logic stable_down;
		age_t debounce_age;
		age_t hold_age;
		age_t press_age;
		logic click_pending;
		logic long_done;
	} lane_state_t;

	typedef struct packed {
		logic down;
		logic pressed;
		logic released;
		logic long_press;
		logic double_click;
	} lane_evt_t;

	typedef struct packed {
		mask_t down_mask;
		mask_t pressed_mask;
		mask_t released_mask;
		mask_t long_press_mask;
		mask_t double_click_mask;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/bdc_ifs.sv
// Interfaces: input, result and configuration channels.
`default_nettype none
interface bdc_in_if;
	logic                valid;
	logic                ready;
	bdc_pkg::mask_t      raw_levels;

	modport source (output valid, output raw_levels, input ready);
	modport sink   (input valid, input raw_levels, output ready);
endinterface

interface bdc_out_if;
	logic                valid;
	logic                ready;
	bdc_pkg::mask_t      down_mask;
	bdc_pkg::mask_t      pressed_mask;
	bdc_pkg::mask_t      released_mask;
	bdc_pkg::mask_t      long_press_mask;
	bdc_pkg::mask_t      double_click_mask;

	modport source (output valid, output down_mask, output pressed_mask,
		output released_mask, output long_press_mask, output double_click_mask,
		input ready);
	modport sink   (input valid, input down_mask, input pressed_mask,
		input released_mask, input long_press_mask, input double_click_mask,
		output ready);
endinterface

interface bdc_cfg_if;
	logic                valid;
	logic                ready;
	bdc_pkg::cfg_idx_t   index;
	bdc_pkg::cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bdc_lane.sv
// One button lane: debounce, press/release, double click and long press.
`default_nettype none
module bdc_lane (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 active,
	input  wire logic                 raw_down,
	input  wire bdc_pkg::timing_cfg_t cfg,
	output bdc_pkg::lane_evt_t        evt
);

	bdc_pkg::lane_state_t state_q;
	bdc_pkg::lane_state_t nxt;
	bdc_pkg::lane_evt_t   e;

	function automatic bdc_pkg::age_t age_up(input bdc_pkg::age_t a);
		return (a == bdc_pkg::AGE_MAX) ? bdc_pkg::AGE_MAX : a + 1'b1;
	endfunction

	always_comb begin
		nxt = state_q;
		e   = '0;
		nxt.debounce_age = age_up(state_q.debounce_age);
		nxt.hold_age     = age_up(state_q.hold_age);
		nxt.press_age    = age_up(state_q.press_age);

		// Restart debounce on any raw edge.
		if (raw_down != state_q.last_raw) begin
			nxt.last_raw     = raw_down;
			nxt.debounce_age = '0;
		end

		if (nxt.debounce_age >= cfg.debounce_ms && state_q.stable_down != raw_down) begin
			nxt.stable_down = raw_down;
			nxt.hold_age    = '0;
			nxt.long_done   = 1'b0;
			if (raw_down) begin
				e.pressed = 1'b1;
				if (state_q.click_pending && nxt.press_age <= cfg.double_click_ms) begin
					e.double_click    = 1'b1;
					nxt.click_pending = 1'b0;
				end else begin
					nxt.click_pending = 1'b1;
					nxt.press_age     = '0;
				end
			end else begin
				e.released = 1'b1;
			end
		end

		// Report a long press once per hold; it cancels a pending click.
		if (nxt.stable_down && !nxt.long_done && nxt.hold_age >= cfg.long_press_ms) begin
			e.long_press      = 1'b1;
			nxt.long_done     = 1'b1;
			nxt.click_pending = 1'b0;
		end

		// Drop an expired click.
		if (nxt.click_pending && nxt.press_age > cfg.double_click_ms) begin
			nxt.click_pending = 1'b0;
		end

		e.down = nxt.stable_down;
	end

	assign evt = active ? e : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step && active) begin
			state_q <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/bdc_merge.sv
// Merge stage: pack lane events into masks and buffer the result item.
`default_nettype none
module bdc_merge #(
	parameter int unsigned LANES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire bdc_pkg::lane_evt_t evt [LANES],
	output logic                    in_ready,
	bdc_out_if.source               out_ch
);

	bdc_pkg::result_t res;
	bdc_pkg::result_t out_q;
	bdc_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             taken;

	always_comb begin
		res = '0;
		for (int i = 0; i < LANES; i++) begin
			res.down_mask[i]         = evt[i].down;
			res.pressed_mask[i]      = evt[i].pressed;
			res.released_mask[i]     = evt[i].released;
			res.long_press_mask[i]   = evt[i].long_press;
			res.double_click_mask[i] = evt[i].double_click;
		end
	end

	assign taken    = out_valid_q && out_ch.ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (taken) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!accept) begin
				out_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (taken) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.down_mask         = out_q.down_mask;
	assign out_ch.pressed_mask      = out_q.pressed_mask;
	assign out_ch.released_mask     = out_q.released_mask;
	assign out_ch.long_press_mask   = out_q.long_press_mask;
	assign out_ch.double_click_mask = out_q.double_click_mask;

endmodule
`default_nettype wire

>>> rtl/core/button_debounce_click_detector_unit.sv
// Top level: button debouncer with press, release, long-press and double-click masks.
`default_nettype none
// Each input item is one millisecond tick carrying the raw active-low levels of up to
// 16 buttons; each item yields exactly one result item with five 16-bit masks: the
// debounced down state and one-tick pulses for press, release, long press and double
// click. Every button has its own lane that updates all of its counters in the cycle
// the item is accepted, so the block takes one item per clock while ready is high.
// Results are registered in a two-entry output buffer (output register plus skid) that
// lets input keep flowing while a result waits; ready drops only when both are full.
// Timing registers (debounce, long press, double click window, in ticks) and the
// active button count are written through the config channel, index 0..3, and reset
// to 50, 1000, 400 and 16; unknown indexes are ignored. Lanes at or above the button
// count freeze their state and report zero. Write config only while idle.
module button_debounce_click_detector_unit #(
	parameter int unsigned BUTTONS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdc_in_if.sink     in_ch,
	bdc_out_if.source  out_ch,
	bdc_cfg_if.sink    cfg_ch
);

	// Only the lanes the mask fields can carry are built.
	localparam int unsigned LANES =
		(BUTTONS < bdc_pkg::FIELD_LANES) ? BUTTONS : bdc_pkg::FIELD_LANES;

	bdc_pkg::timing_cfg_t cfg_q;
	bdc_pkg::count_t      button_count_q;
	bdc_pkg::lane_evt_t   evt [LANES];
	logic                 merge_ready;
	logic                 accept;

	// Configuration writes are always taken.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bdc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms   <= bdc_pkg::LONG_PRESS_RST;
			cfg_q.double_click_ms <= bdc_pkg::DOUBLE_CLICK_RST;
			button_count_q        <= bdc_pkg::BUTTON_COUNT_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				bdc_pkg::REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_ch.data;
				bdc_pkg::REG_LONG_PRESS:   cfg_q.long_press_ms   <= cfg_ch.data;
				bdc_pkg::REG_DOUBLE_CLICK: cfg_q.double_click_ms <= cfg_ch.data;
				bdc_pkg::REG_BUTTON_COUNT: button_count_q        <=
					cfg_ch.data[bdc_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Accept an item whenever the output buffer has room.
	assign in_ch.ready = merge_ready;
	assign accept      = in_ch.valid && merge_ready;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		// A count above the built lanes simply enables all of them.
		bdc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (accept),
			.active   (button_count_q > bdc_pkg::COUNT_W'(i)),
			.raw_down (!in_ch.raw_levels[i]),
			.cfg      (cfg_q),
			.evt      (evt[i])
		);
	end

	bdc_merge #(
		.LANES (LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.evt      (evt),
		.in_ready (merge_ready),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

>>> rtl/core/bdc_checker.sv
// Checker: port-level properties of the debounce and click detector, with its bind.
`default_nettype none
module bdc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire bdc_pkg::mask_t down_mask,
	input wire bdc_pkg::mask_t pressed_mask,
	input wire bdc_pkg::mask_t released_mask,
	input wire bdc_pkg::mask_t long_press_mask,
	input wire bdc_pkg::mask_t double_click_mask
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressed_mask)
			&& $stable(down_mask))
		else $error("stalled result item changed or vanished");

	a_press_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pressed_mask & released_mask) == '0))
		else $error("press and release in the same tick");

	a_edges_match_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pressed_mask & ~down_mask) == '0)
			&& ((released_mask & down_mask) == '0))
		else $error("press or release disagrees with down state");

	a_double_is_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((double_click_mask & ~pressed_mask) == '0)
			&& ((long_press_mask & ~down_mask) == '0))
		else $error("double click without press or long press while up");

endmodule

bind button_debounce_click_detector_unit bdc_checker u_bdc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.down_mask         (out_ch.down_mask),
	.pressed_mask      (out_ch.pressed_mask),
	.released_mask     (out_ch.released_mask),
	.long_press_mask   (out_ch.long_press_mask),
	.double_click_mask (out_ch.double_click_mask)
);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench: predicts the debounce, press, release, long-press and double-click masks per tick.
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 36;

	// Predicts each tick's five masks and checks the results that come back in order.
	class button_event_scoreboard;
		bdc_pkg::age_t   debounce_ms;
		bdc_pkg::age_t   long_press_ms;
		bdc_pkg::age_t   double_click_ms;
		bdc_pkg::count_t button_count;

		bit            last_raw[bdc_pkg::FIELD_LANES];
		bit            stable_down[bdc_pkg::FIELD_LANES];
		bdc_pkg::age_t debounce_age[bdc_pkg::FIELD_LANES];
		bdc_pkg::age_t hold_age[bdc_pkg::FIELD_LANES];
		bdc_pkg::age_t press_age[bdc_pkg::FIELD_LANES];
		bit            click_pending[bdc_pkg::FIELD_LANES];
		bit            long_done[bdc_pkg::FIELD_LANES];

		bdc_pkg::result_t expected_masks[$];
		int               failures;

		function new();
			debounce_ms     = bdc_pkg::DEBOUNCE_RST;
			long_press_ms   = bdc_pkg::LONG_PRESS_RST;
			double_click_ms = bdc_pkg::DOUBLE_CLICK_RST;
			button_count    = bdc_pkg::BUTTON_COUNT_RST;
			failures        = 0;
			for (int i = 0; i < bdc_pkg::FIELD_LANES; i++) begin
				last_raw[i]      = 1'b0;
				stable_down[i]   = 1'b0;
				debounce_age[i]  = '0;
				hold_age[i]      = '0;
				press_age[i]     = '0;
				click_pending[i] = 1'b0;
				long_done[i]     = 1'b0;
			end
		endfunction

		function void write_reg(bdc_pkg::cfg_idx_t idx, bdc_pkg::cfg_data_t val);
			case (idx)
				bdc_pkg::REG_DEBOUNCE:     debounce_ms     = val;
				bdc_pkg::REG_LONG_PRESS:   long_press_ms   = val;
				bdc_pkg::REG_DOUBLE_CLICK: double_click_ms = val;
				bdc_pkg::REG_BUTTON_COUNT: button_count    = val[bdc_pkg::COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		static function bdc_pkg::age_t age_up(bdc_pkg::age_t a);
			return (a == bdc_pkg::AGE_MAX) ? a : bdc_pkg::age_t'(a + 1'b1);
		endfunction

		function bdc_pkg::result_t predict_tick(bdc_pkg::mask_t levels);
			bdc_pkg::result_t r;
			int               lanes;
			bit               raw;
			r = '0;
			lanes = (button_count > bdc_pkg::FIELD_LANES) ? int'(bdc_pkg::FIELD_LANES)
				: int'(button_count);
			for (int i = 0; i < lanes; i++) begin
				raw = !levels[i];
				debounce_age[i] = age_up(debounce_age[i]);
				hold_age[i]     = age_up(hold_age[i]);
				press_age[i]    = age_up(press_age[i]);
				if (raw != last_raw[i]) begin
					last_raw[i]     = raw;
					debounce_age[i] = '0;
				end
				if (debounce_age[i] >= debounce_ms && stable_down[i] != raw) begin
					stable_down[i] = raw;
					hold_age[i]    = '0;
					long_done[i]   = 1'b0;
					if (raw) begin
						r.pressed_mask[i] = 1'b1;
						if (click_pending[i] && press_age[i] <= double_click_ms) begin
							r.double_click_mask[i] = 1'b1;
							click_pending[i]       = 1'b0;
						end else begin
							click_pending[i] = 1'b1;
							press_age[i]     = '0;
						end
					end else begin
						r.released_mask[i] = 1'b1;
					end
				end
				if (stable_down[i] && !long_done[i] && hold_age[i] >= long_press_ms) begin
					r.long_press_mask[i] = 1'b1;
					long_done[i]         = 1'b1;
					click_pending[i]     = 1'b0;
				end
				if (click_pending[i] && press_age[i] > double_click_ms)
					click_pending[i] = 1'b0;
				r.down_mask[i] = stable_down[i];
			end
			return r;
		endfunction

		function void note_tick(bdc_pkg::mask_t levels);
			expected_masks.push_back(predict_tick(levels));
		endfunction

		function void compare_field(string name, bdc_pkg::mask_t want, bdc_pkg::mask_t got);
			if (want !== got) begin
				failures++;
				$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_masks(bdc_pkg::result_t got);
			bdc_pkg::result_t want;
			if (expected_masks.size() == 0) begin
				failures++;
				$display("%0t unexpected result: expected none actual %h", $time, got);
				return;
			end
			want = expected_masks.pop_front();
			compare_field("down_mask", want.down_mask, got.down_mask);
			compare_field("pressed_mask", want.pressed_mask, got.pressed_mask);
			compare_field("released_mask", want.released_mask, got.released_mask);
			compare_field("long_press_mask", want.long_press_mask, got.long_press_mask);
			compare_field("double_click_mask", want.double_click_mask,
				got.double_click_mask);
		endfunction

		function int pending();
			return expected_masks.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bdc_in_if  in_ch();
	bdc_out_if out_ch();
	bdc_cfg_if cfg_ch();

	button_event_scoreboard sb = new();

	// Calm stretches drop all idling on both sides.
	bit calm;
	int cycles;

	// Per-lane button intent for well-formed press/release sequences.
	bit held[bdc_pkg::FIELD_LANES];
	int dwell[bdc_pkg::FIELD_LANES];

	// Timing in effect, kept here to size the dwell times.
	int cur_debounce;
	int cur_long;
	int cur_double;

	button_debounce_click_detector_unit #(.BUTTONS(16)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random; hold ready high while calm.
	always @(negedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Observe every handshake at the rising edge: config writes and ticks feed the
	// predictor, results are checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
			if (in_ch.valid && in_ch.ready)
				sb.note_tick(in_ch.raw_levels);
			if (out_ch.valid && out_ch.ready)
				sb.check_masks(bdc_pkg::result_t'({out_ch.down_mask,
					out_ch.pressed_mask, out_ch.released_mask,
					out_ch.long_press_mask, out_ch.double_click_mask}));
		end
	end

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Send one tick; idle at random first, leave valid high on return so a
	// following tick keeps it up without a glitch.
	task automatic send_tick(bdc_pkg::mask_t lv);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.raw_levels <= lv;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// Write one register; valid stays high for a following write.
	task automatic write_reg(bdc_pkg::cfg_idx_t idx, bdc_pkg::cfg_data_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Drain, then write all four registers while the block is idle.
	task automatic apply_timing(int deb, int lng, int dbl, int cnt);
		drain();
		write_reg(bdc_pkg::REG_DEBOUNCE, bdc_pkg::cfg_data_t'(deb));
		write_reg(bdc_pkg::REG_LONG_PRESS, bdc_pkg::cfg_data_t'(lng));
		write_reg(bdc_pkg::REG_DOUBLE_CLICK, bdc_pkg::cfg_data_t'(dbl));
		write_reg(bdc_pkg::REG_BUTTON_COUNT, bdc_pkg::cfg_data_t'(cnt));
		cfg_ch.valid <= 1'b0;
		cur_debounce = (deb > 100) ? 100 : deb;
		cur_long     = (lng > 100) ? 100 : lng;
		cur_double   = (dbl > 100) ? 100 : dbl;
	endtask

	// Mix short taps (double-click range) with long holds (long-press range).
	function automatic int pick_dwell();
		if ($urandom_range(1))
			return $urandom_range(cur_debounce + 1, cur_debounce + cur_double / 2 + 2);
		return $urandom_range(1, cur_debounce + cur_long + 6);
	endfunction

	// Advance each lane's intent and add an occasional one-tick bounce.
	function automatic bdc_pkg::mask_t next_levels();
		bdc_pkg::mask_t lv;
		for (int i = 0; i < bdc_pkg::FIELD_LANES; i++) begin
			if (dwell[i] == 0) begin
				held[i]  = !held[i];
				dwell[i] = pick_dwell();
			end
			dwell[i]--;
			lv[i] = !held[i];
			if ($urandom_range(15) == 0)
				lv[i] = !lv[i];
		end
		return lv;
	endfunction

	initial begin
		int cnt;
		int n;
		in_ch.valid      = 1'b0;
		in_ch.raw_levels = '1;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = bdc_pkg::REG_DEBOUNCE;
		cfg_ch.data      = '0;
		out_ch.ready     = 1'b0;
		calm             = 1'b0;
		cycles           = 0;
		cur_debounce     = bdc_pkg::DEBOUNCE_RST;
		cur_long         = 100;
		cur_double       = 100;
		for (int i = 0; i < bdc_pkg::FIELD_LANES; i++) begin
			held[i]  = 1'b0;
			dwell[i] = 0;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset timings: levels move but nothing is accepted yet.
		send_tick(16'hFFFF);
		send_tick(16'h0000);
		send_tick(16'hAAAA);

		// Zero timings: accept at once, long press in the press tick itself,
		// which also cancels the pending click.
		apply_timing(0, 0, 0, 16);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h0000);
		send_tick(16'hFFFF);

		// Widest window, no long press: the second press is a double click.
		apply_timing(0, 65535, 65535, 16);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h0000);
		send_tick(16'h5555);
		send_tick(16'hAAAA);

		// Longest debounce, count above the lane range.
		apply_timing(65535, 0, 400, 31);
		send_tick(16'h0000);
		send_tick(16'hFFFF);

		// No active lanes: every mask reads zero, state stays frozen.
		apply_timing(0, 0, 0, 0);
		send_tick(16'h0000);
		send_tick(16'hFFFF);

		// Count just above the lanes with short timings.
		apply_timing(1, 2, 3, 17);
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'hFFFF);

		// Random phases: mostly well-formed press sequences, some noise.
		for (int p = 0; p < 10; p++) begin
			cnt = ($urandom_range(9) < 6) ? 16 : $urandom_range(0, 31);
			case (p)
				0:       apply_timing(bdc_pkg::DEBOUNCE_RST, bdc_pkg::LONG_PRESS_RST,
					bdc_pkg::DOUBLE_CLICK_RST, 16);
				3:       apply_timing($urandom_range(0, 4), 65535, 65535, cnt);
				7:       apply_timing(0, $urandom_range(0, 8), 0, cnt);
				default: apply_timing($urandom_range(0, 6), $urandom_range(0, 25),
					$urandom_range(0, 30), cnt);
			endcase
			calm = (p == 5);
			n = (p == 0) ? 150 : 95;
			for (int k = 0; k < n; k++) begin
				// Pause mid-phase once until all results are back.
				if (p == 2 && k == n / 2)
					drain();
				if ($urandom_range(99) < 15)
					send_tick(bdc_pkg::mask_t'($urandom()));
				else
					send_tick(next_levels());
			end
			calm = 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bdc_pkg.sv
rtl/core/bdc_ifs.sv
rtl/core/bdc_lane.sv
rtl/core/bdc_merge.sv
rtl/core/button_debounce_click_detector_unit.sv
rtl/core/bdc_checker.sv
sim/testbench.sv
